// File: rtl/tgm_pkg.sv
// Types, codes and fixed constants shared by the touch gesture mode recogniser.
// No dependencies; compile first.
`timescale 1ns / 1ps

package tgm_pkg;

    // Fixed field widths
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DELTA_W   = 16;
    localparam int THR_W     = 15;
    localparam int EDGE_W    = 24;
    localparam int DRAG_W    = 20;

    // Slope window: -1.535*dx < dy < -0.65*dx, scaled by 1000
    localparam int SLOPE_DY_K   = 1000;
    localparam int SLOPE_STEEP_K = 1535;
    localparam int SLOPE_FLAT_K = 650;

    localparam logic signed [EDGE_W-1:0] EDGE_MAX = {1'b0, {(EDGE_W-1){1'b1}}};
    localparam logic signed [EDGE_W-1:0] EDGE_MIN = {1'b1, {(EDGE_W-1){1'b0}}};
    localparam logic [DRAG_W-1:0]        DRAG_MAX = {DRAG_W{1'b1}};

    // Register reset values
    localparam logic [THR_W-1:0] RST_EDGE_DEADZONE  = 15'd26;
    localparam logic [THR_W-1:0] RST_EDGE_STEP_THR  = 15'd410;
    localparam logic [CFG_W-1:0] RST_CORNER_RADIUS  = 16'd386;
    localparam logic [CFG_W-1:0] RST_DRAG_TRIGGER   = 16'd400;
    localparam logic [CFG_W-1:0] RST_PAD_HEIGHT     = 16'd0;
    localparam logic [CFG_W-1:0] RST_RETURN_X       = 16'd720;
    localparam logic [CFG_W-1:0] RST_RETURN_Y       = 16'd1920;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_DEADZONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_STEP_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_TRIGGER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_Y      = 3'd6;

    typedef enum logic [1:0] {
        MODE_INHIBIT = 2'd0,
        MODE_QUALIFY = 2'd1,
        MODE_GLASS   = 2'd2,
        MODE_MENU    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KEY_NONE    = 3'd0,
        KEY_TAB     = 3'd1,
        KEY_STAB    = 3'd2,
        KEY_MENU    = 3'd3,
        KEY_CONFIRM = 3'd4
    } key_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE,
        S_DISPATCH,
        S_SLOPE0,
        S_SLOPE1,
        S_SLOPE2,
        S_SLOPE3,
        S_SQ_A,
        S_SQ_B,
        S_SQ_SUM,
        S_RAD,
        S_CMP,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DRAG_ADD,
        S_DRAG_CHK,
        S_EMIT
    } tgm_state_t;

    // Square root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

// File: rtl/tgm_if.sv
// Handshake channels of the touch gesture mode recogniser: report in, result out,
// register write. Depends on tgm_pkg.
`timescale 1ns / 1ps

interface tgm_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          touching;
    logic [COORD_WIDTH-1:0]        pos_x;
    logic [COORD_WIDTH-1:0]        pos_y;
    logic signed [tgm_pkg::DELTA_W-1:0] edge_delta;

    modport source (output valid, touching, pos_x, pos_y, edge_delta, input ready);
    modport sink   (input valid, touching, pos_x, pos_y, edge_delta, output ready);
endinterface

interface tgm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] key_first;
    logic [2:0] key_second;

    modport source (output valid, mode, key_first, key_second, input ready);
    modport sink   (input valid, mode, key_first, key_second, output ready);
endinterface

interface tgm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tgm_pkg::CFG_IDX_W-1:0]   index;
    logic [tgm_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tgm_isqrt.sv
// Iterative integer square root, one result bit per cycle (floor of the root).
// Depends on tgm_pkg for the status struct.
`timescale 1ns / 1ps

module tgm_isqrt #(
    parameter int W = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         radicand,
    output logic [(W+1)/2-1:0]   root,
    output tgm_pkg::sqrt_stat_t  stat
);
    import tgm_pkg::*;

    localparam int RW   = (W + 1) / 2;
    localparam int RADW = 2 * RW;
    localparam int CNTW = $clog2(RW + 1);

    logic [RADW-1:0] rad_reg,  rad_next;
    logic [RW+1:0]   rem_reg,  rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CNTW-1:0] cnt_reg,  cnt_next;
    logic            done_reg, done_next;

    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            fits;

    // Bring down the next pair of radicand bits and try the next root bit
    assign rem_sh = {rem_reg[RW-1:0], rad_reg[RADW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RADW'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNTW'(RW);
        end
        else if (cnt_reg != '0)
        begin
            rad_next = {rad_reg[RADW-3:0], 2'b00};
            if (fits)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNTW'(1);
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    // Hold iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// File: rtl/touch_gesture_mode_recognizer_top.sv
// Top level of the touch gesture mode recogniser: edge accumulator, mode
// sequencer, shared multiplier. Depends on tgm_pkg, tgm_if.sv and tgm_isqrt.
//
//   Channel | Dir | Beat content
//   --------+-----+------------------------------------------------
//   rpt     | in  | touching, pos_x, pos_y, edge_delta (one report tick)
//   res     | out | mode, key_first, key_second (one per report)
//   cfg     | in  | index, data (register write, always ready)
//
// A report passes the edge, dispatch and emit states when no corner or drag test
// runs; a corner test adds the squared-distance and radius states, and a measured
// drag step adds the slope states and the bit-serial square root, the longest path.
// rpt.ready is high only while the sequencer is idle. A result waits in the
// output register; a stalled res holds the next result in its final state.
// Reset restores registers and mode (menu) and clears both accumulators.
`timescale 1ns / 1ps

module touch_gesture_mode_recognizer_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tgm_in_if.sink    rpt,
    tgm_out_if.source res,
    tgm_cfg_if.sink   cfg
);
    import tgm_pkg::*;

    localparam int AW   = (COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W;
    localparam int PW   = 2 * AW;
    localparam int SUMW = PW + 1;
    localparam int RW   = (SUMW + 1) / 2;
    localparam int DSW  = ((RW > DRAG_W) ? RW : DRAG_W) + 1;
    localparam logic [SUMW-1:0] SQ_CAP =
        (SUMW > 64) ? {1'b0, {(SUMW-1){1'b1}}} : {SUMW{1'b1}};

    // Configuration registers
    logic [THR_W-1:0] dz_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CFG_W-1:0] radius_reg;
    logic [CFG_W-1:0] trigger_reg;
    logic [CFG_W-1:0] pad_h_reg;
    logic [CFG_W-1:0] ret_x_reg;
    logic [CFG_W-1:0] ret_y_reg;

    // Control and architectural state
    tgm_state_t               state_reg,      state_next;
    mode_t                    mode_reg,       mode_next;
    logic signed [EDGE_W-1:0] edge_reg,       edge_next;
    logic [DRAG_W-1:0]        drag_reg,       drag_next;
    logic                     prev_touch_reg, prev_touch_next;
    logic [COORD_WIDTH-1:0]   prev_x_reg,     prev_x_next;
    logic [COORD_WIDTH-1:0]   prev_y_reg,     prev_y_next;
    logic                     out_valid_reg,  out_valid_next;

    // Per-report working registers
    logic                      touch_reg,    touch_next;
    logic [COORD_WIDTH-1:0]    x_reg,        x_next;
    logic [COORD_WIDTH-1:0]    y_reg,        y_next;
    logic signed [DELTA_W-1:0] delta_reg,    delta_next;
    logic                      down_reg,     down_next;
    logic                      dx_pos_reg,   dx_pos_next;
    logic                      dy_neg_reg,   dy_neg_next;
    logic [AW-1:0]             a_mag_reg,    a_mag_next;
    logic [AW-1:0]             b_mag_reg,    b_mag_next;
    logic                      is_drag_reg,  is_drag_next;
    mode_t                     hit_mode_reg, hit_mode_next;
    logic                      slope_lo_reg, slope_lo_next;
    logic [PW-1:0]             prod_reg,     prod_next;
    logic [SUMW-1:0]           acc_reg,      acc_next;
    key_t                      k1_reg,       k1_next;
    key_t                      k2_reg,       k2_next;
    mode_t                     out_mode_reg, out_mode_next;
    key_t                      out_k1_reg,   out_k1_next;
    key_t                      out_k2_reg,   out_k2_next;

    // Shared multiplier and square root hookup
    logic [AW-1:0]    mul_a;
    logic [AW-1:0]    mul_b;
    logic [PW-1:0]    mul_p;
    logic             sqrt_start;
    logic [RW-1:0]    sqrt_root;
    sqrt_stat_t       sqrt_stat;

    // Combinational helpers
    logic signed [DELTA_W:0]  delta_ext;
    logic signed [DELTA_W:0]  dz_ext;
    logic                     beyond_dz;
    logic signed [EDGE_W:0]   edge_sum;
    logic signed [EDGE_W-1:0] edge_sat;
    logic signed [EDGE_W:0]   edge_ext;
    logic signed [EDGE_W:0]   dz_cmp;
    logic signed [EDGE_W:0]   thr_cmp;
    logic [CFG_W-1:0]         cx_cfg;
    logic [CFG_W-1:0]         cy_cfg;
    logic [AW:0]              ref_x;
    logic [AW:0]              ref_y;
    logic signed [AW:0]       dx_s;
    logic signed [AW:0]       dy_s;
    logic [AW:0]              dx_neg;
    logic [AW:0]              dy_neg;
    logic [SUMW-1:0]          sq_full;
    logic [SUMW-1:0]          sq_sat;
    logic [DSW-1:0]           drag_sum;

    tgm_isqrt #(
        .W (SUMW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    assign mul_p = mul_a * mul_b;

    // Edge delta outside the deadzone, saturating sum
    assign delta_ext = {delta_reg[DELTA_W-1], delta_reg};
    assign dz_ext    = signed'({2'b00, dz_reg});
    assign beyond_dz = (delta_ext > dz_ext) || (delta_ext < -dz_ext);
    assign edge_sum  = {edge_reg[EDGE_W-1], edge_reg}
                     + {{(EDGE_W-DELTA_W+1){delta_reg[DELTA_W-1]}}, delta_reg};
    assign edge_sat  = (edge_sum[EDGE_W] != edge_sum[EDGE_W-1])
                     ? (edge_sum[EDGE_W] ? EDGE_MIN : EDGE_MAX)
                     : edge_sum[EDGE_W-1:0];
    assign edge_ext  = {edge_reg[EDGE_W-1], edge_reg};
    assign dz_cmp    = signed'({{(EDGE_W-THR_W+1){1'b0}}, dz_reg});
    assign thr_cmp   = signed'({{(EDGE_W-THR_W+1){1'b0}}, thr_reg});

    // Reference point: corner for inhibit and glassing, previous sample for the drag
    assign cx_cfg = (mode_reg == MODE_GLASS) ? ret_x_reg : '0;
    assign cy_cfg = (mode_reg == MODE_GLASS) ? ret_y_reg : pad_h_reg;
    assign ref_x  = (mode_reg == MODE_QUALIFY) ? (AW+1)'(prev_x_reg) : (AW+1)'(cx_cfg);
    assign ref_y  = (mode_reg == MODE_QUALIFY) ? (AW+1)'(prev_y_reg) : (AW+1)'(cy_cfg);
    assign dx_s   = signed'((AW+1)'(x_reg) - ref_x);
    assign dy_s   = signed'((AW+1)'(y_reg) - ref_y);
    assign dx_neg = -dx_s;
    assign dy_neg = -dy_s;

    // Sum of squares, capped at SQ_CAP: SUMW ones, or SUMW-1 ones above 64 bits
    assign sq_full  = acc_reg + SUMW'(prod_reg);
    assign sq_sat   = (sq_full > SQ_CAP) ? SQ_CAP : sq_full;
    assign drag_sum = DSW'(drag_reg) + DSW'(sqrt_root);

    // Sequencer: next state, datapath steps and operand selection
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        edge_next       = edge_reg;
        drag_next       = drag_reg;
        prev_touch_next = prev_touch_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        out_valid_next  = out_valid_reg;
        touch_next      = touch_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        delta_next      = delta_reg;
        down_next       = down_reg;
        dx_pos_next     = dx_pos_reg;
        dy_neg_next     = dy_neg_reg;
        a_mag_next      = a_mag_reg;
        b_mag_next      = b_mag_reg;
        is_drag_next    = is_drag_reg;
        hit_mode_next   = hit_mode_reg;
        slope_lo_next   = slope_lo_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        out_mode_next   = out_mode_reg;
        out_k1_next     = out_k1_reg;
        out_k2_next     = out_k2_reg;
        mul_a           = '0;
        mul_b           = '0;
        sqrt_start      = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (rpt.valid)
                begin
                    touch_next = rpt.touching;
                    x_next     = rpt.pos_x;
                    y_next     = rpt.pos_y;
                    delta_next = rpt.edge_delta;
                    k1_next    = KEY_NONE;
                    k2_next    = KEY_NONE;
                    state_next = S_EDGE;
                end
            end

            S_EDGE:
            begin
                if (beyond_dz)
                begin
                    edge_next = edge_sat;
                end
                down_next       = touch_reg && !prev_touch_reg;
                dx_pos_next     = !dx_s[AW] && (dx_s != '0);
                dy_neg_next     = dy_s[AW];
                a_mag_next      = dx_s[AW] ? dx_neg[AW-1:0] : dx_s[AW-1:0];
                b_mag_next      = dy_s[AW] ? dy_neg[AW-1:0] : dy_s[AW-1:0];
                prev_touch_next = touch_reg;
                prev_x_next     = x_reg;
                prev_y_next     = y_reg;
                state_next      = S_DISPATCH;
            end

            S_DISPATCH:
            begin
                is_drag_next = 1'b0;
                case (mode_reg)
                    MODE_INHIBIT:
                    begin
                        hit_mode_next = MODE_QUALIFY;
                        state_next    = down_reg ? S_SQ_A : S_EMIT;
                    end
                    MODE_QUALIFY:
                    begin
                        if (!touch_reg)
                        begin
                            drag_next  = '0;
                            mode_next  = MODE_INHIBIT;
                            state_next = S_EMIT;
                        end
                        else if (dx_pos_reg && dy_neg_reg)
                        begin
                            is_drag_next = 1'b1;
                            state_next   = S_SLOPE0;
                        end
                        else
                        begin
                            state_next = S_DRAG_CHK;
                        end
                    end
                    MODE_GLASS:
                    begin
                        if (edge_ext > dz_cmp)
                        begin
                            k1_next   = KEY_MENU;
                            edge_next = '0;
                            mode_next = MODE_MENU;
                        end
                        hit_mode_next = MODE_INHIBIT;
                        state_next    = down_reg ? S_SQ_A : S_EMIT;
                    end
                    default:
                    begin
                        if (edge_ext > thr_cmp)
                        begin
                            k1_next   = KEY_TAB;
                            edge_next = '0;
                        end
                        else if (edge_ext < -thr_cmp)
                        begin
                            k1_next   = KEY_STAB;
                            edge_next = '0;
                        end
                        if (!touch_reg)
                        begin
                            if ((edge_ext > thr_cmp) || (edge_ext < -thr_cmp))
                            begin
                                k2_next = KEY_CONFIRM;
                            end
                            else
                            begin
                                k1_next = KEY_CONFIRM;
                            end
                            mode_next = MODE_INHIBIT;
                        end
                        state_next = S_EMIT;
                    end
                endcase
            end

            // Slope window: 650*dx < 1000*|dy| < 1535*dx
            S_SLOPE0:
            begin
                mul_a      = b_mag_reg;
                mul_b      = AW'(SLOPE_DY_K);
                prod_next  = mul_p;
                state_next = S_SLOPE1;
            end

            S_SLOPE1:
            begin
                acc_next   = SUMW'(prod_reg);
                mul_a      = a_mag_reg;
                mul_b      = AW'(SLOPE_STEEP_K);
                prod_next  = mul_p;
                state_next = S_SLOPE2;
            end

            S_SLOPE2:
            begin
                slope_lo_next = (acc_reg < SUMW'(prod_reg));
                mul_a         = a_mag_reg;
                mul_b         = AW'(SLOPE_FLAT_K);
                prod_next     = mul_p;
                state_next    = S_SLOPE3;
            end

            S_SLOPE3:
            begin
                if (slope_lo_reg && (SUMW'(prod_reg) < acc_reg))
                begin
                    state_next = S_SQ_A;
                end
                else
                begin
                    state_next = S_DRAG_CHK;
                end
            end

            // Squared distance through the shared multiplier
            S_SQ_A:
            begin
                mul_a      = a_mag_reg;
                mul_b      = a_mag_reg;
                prod_next  = mul_p;
                state_next = S_SQ_B;
            end

            S_SQ_B:
            begin
                acc_next   = SUMW'(prod_reg);
                mul_a      = b_mag_reg;
                mul_b      = b_mag_reg;
                prod_next  = mul_p;
                state_next = S_SQ_SUM;
            end

            S_SQ_SUM:
            begin
                acc_next   = sq_sat;
                state_next = is_drag_reg ? S_ROOT_GO : S_RAD;
            end

            S_RAD:
            begin
                mul_a      = AW'(radius_reg);
                mul_b      = AW'(radius_reg);
                prod_next  = mul_p;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (acc_reg < SUMW'(prod_reg))
                begin
                    mode_next = hit_mode_reg;
                end
                state_next = S_EMIT;
            end

            S_ROOT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = S_ROOT_WAIT;
            end

            S_ROOT_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_DRAG_ADD;
                end
            end

            S_DRAG_ADD:
            begin
                drag_next  = (drag_sum > DSW'(DRAG_MAX)) ? DRAG_MAX : drag_sum[DRAG_W-1:0];
                state_next = S_DRAG_CHK;
            end

            S_DRAG_CHK:
            begin
                if (drag_reg > DRAG_W'(trigger_reg))
                begin
                    drag_next = '0;
                    edge_next = '0;
                    mode_next = MODE_GLASS;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mode_next  = mode_reg;
                    out_k1_next    = k1_reg;
                    out_k2_next    = k2_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state, architectural state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_MENU;
            edge_reg       <= '0;
            drag_reg       <= '0;
            prev_touch_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
            dz_reg         <= RST_EDGE_DEADZONE;
            thr_reg        <= RST_EDGE_STEP_THR;
            radius_reg     <= RST_CORNER_RADIUS;
            trigger_reg    <= RST_DRAG_TRIGGER;
            pad_h_reg      <= RST_PAD_HEIGHT;
            ret_x_reg      <= RST_RETURN_X;
            ret_y_reg      <= RST_RETURN_Y;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            edge_reg       <= edge_next;
            drag_reg       <= drag_next;
            prev_touch_reg <= prev_touch_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_EDGE_DEADZONE: dz_reg      <= cfg.data[THR_W-1:0];
                    REG_EDGE_STEP_THR: thr_reg     <= cfg.data[THR_W-1:0];
                    REG_CORNER_RADIUS: radius_reg  <= cfg.data;
                    REG_DRAG_TRIGGER:  trigger_reg <= cfg.data;
                    REG_PAD_HEIGHT:    pad_h_reg   <= cfg.data;
                    REG_RETURN_X:      ret_x_reg   <= cfg.data;
                    REG_RETURN_Y:      ret_y_reg   <= cfg.data;
                    default:           ;
                endcase
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        touch_reg    <= touch_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        delta_reg    <= delta_next;
        down_reg     <= down_next;
        dx_pos_reg   <= dx_pos_next;
        dy_neg_reg   <= dy_neg_next;
        a_mag_reg    <= a_mag_next;
        b_mag_reg    <= b_mag_next;
        is_drag_reg  <= is_drag_next;
        hit_mode_reg <= hit_mode_next;
        slope_lo_reg <= slope_lo_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        out_mode_reg <= out_mode_next;
        out_k1_reg   <= out_k1_next;
        out_k2_reg   <= out_k2_next;
    end

    assign rpt.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign res.valid      = out_valid_reg;
    assign res.mode       = out_mode_reg;
    assign res.key_first  = out_k1_reg;
    assign res.key_second = out_k2_reg;

endmodule

// File: rtl/tgm_checker.sv
// Port-level checks for the touch gesture mode recogniser, bound to its top level.
// Depends on tgm_pkg and touch_gesture_mode_recognizer_top.
`timescale 1ns / 1ps

module tgm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_mode,
    input logic [2:0] out_key_first,
    input logic [2:0] out_key_second
);
    import tgm_pkg::*;

    // One report at a time: not ready straight after a beat is taken
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("report taken while the previous one is still in work");

    // A report's result cannot appear straight after its beat is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised one cycle after the report beat");

    // A second key is only enter after tab or shift-tab, and comes with a return to inhibit
    a_second_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_key_second != KEY_NONE) |->
            (out_key_second == KEY_CONFIRM) && (out_mode == MODE_INHIBIT)
            && (out_key_first == KEY_TAB || out_key_first == KEY_STAB))
        else $error("second key without tab or shift-tab before enter");

    // Enter as first key always comes with a return to inhibit
    a_enter_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_key_first == KEY_CONFIRM) |-> (out_mode == MODE_INHIBIT))
        else $error("enter reported outside inhibit");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mode)
            && $stable(out_key_first) && $stable(out_key_second))
        else $error("stalled result changed");

endmodule

bind touch_gesture_mode_recognizer_top tgm_checker u_tgm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rpt.valid),
    .in_ready       (rpt.ready),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .out_mode       (res.mode),
    .out_key_first  (res.key_first),
    .out_key_second (res.key_second)
);
